@@ hdl/csrmv_pkg.sv @@
package csrmv_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int ROW_DEPTH    = 1024;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 48;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int FRAC_W  = 16;

    localparam logic [INDEX_W-1:0] ROW_LAST = INDEX_W'(ROW_DEPTH - 1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // half-lsb offset for round half up when dropping the low fraction bits
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

    typedef enum logic [1:0] {
        MODE_LOAD_VEC  = 2'd0,
        MODE_LOAD_BASE = 2'd1,
        MODE_ROW       = 2'd2,
        MODE_RESTART   = 2'd3
    } t_mode;

    // per-beat control that travels down the pipe
    typedef struct packed {
        logic               is_mac;
        logic               is_last;
        logic               is_rst;
        logic [INDEX_W-1:0] row;
    } t_ctl;

    // store access commands for one cycle
    typedef struct packed {
        logic wr_vec;
        logic wr_base;
        logic rd_en;
    } t_store_cmd;

    typedef struct packed {
        logic                    hit;
        logic signed [SUM_W-1:0] value;
    } t_sat;

    function automatic t_sat sat_add(input logic signed [SUM_W-1:0] a,
                                     input logic signed [SUM_W-1:0] b);
        logic signed [SUM_W:0] s;
        t_sat                  r;
        s = $signed({a[SUM_W-1], a}) + $signed({b[SUM_W-1], b});
        if (s[SUM_W] != s[SUM_W-1]) begin
            r.hit   = 1'b1;
            r.value = s[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            r.hit   = 1'b0;
            r.value = s[SUM_W-1:0];
        end
        return r;
    endfunction

    // Q32.32 product down to Q32.16, round half up
    function automatic logic signed [SUM_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = p + ROUND_HALF;
        return q[FRAC_W+SUM_W-1:FRAC_W];
    endfunction

endpackage

@@ hdl/csrmv_if.sv @@
interface csrmv_in_if;
    import csrmv_pkg::*;

    logic                      valid;
    logic                      ready;
    t_mode                     mode;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] entry_value;
    logic signed [SUM_W-1:0]   base_value;
    logic                      entry_present;
    logic                      last_in_row;

    modport source (output valid, output mode, output index, output entry_value,
                    output base_value, output entry_present, output last_in_row,
                    input ready);
    modport sink   (input valid, input mode, input index, input entry_value,
                    input base_value, input entry_present, input last_in_row,
                    output ready);
endinterface

interface csrmv_out_if;
    import csrmv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [INDEX_W-1:0]      row_index;
    logic signed [SUM_W-1:0] row_sum;
    logic                    saturated;

    modport source (output valid, output row_index, output row_sum, output saturated,
                    input ready);
    modport sink   (input valid, input row_index, input row_sum, input saturated,
                    output ready);
endinterface

@@ hdl/csrmv_stores.sv @@
module csrmv_stores (
    input  logic                                i_clk,
    input  csrmv_pkg::t_store_cmd               i_cmd,
    input  logic [csrmv_pkg::INDEX_W-1:0]       i_index,
    input  logic [csrmv_pkg::INDEX_W-1:0]       i_base_addr,
    input  logic signed [csrmv_pkg::VALUE_W-1:0] i_entry_value,
    input  logic signed [csrmv_pkg::SUM_W-1:0]  i_base_value,
    output logic signed [csrmv_pkg::VALUE_W-1:0] o_vec_rdata,
    output logic signed [csrmv_pkg::SUM_W-1:0]  o_base_rdata
);
    import csrmv_pkg::*;

    logic signed [VALUE_W-1:0] r_vec_mem  [VECTOR_DEPTH];
    logic signed [SUM_W-1:0]   r_base_mem [ROW_DEPTH];
    logic signed [VALUE_W-1:0] r_vec_rdata;
    logic signed [SUM_W-1:0]   r_base_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_vec) begin
            r_vec_mem[i_index] <= i_entry_value;
        end
        if (i_cmd.rd_en) begin
            r_vec_rdata <= r_vec_mem[i_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_base) begin
            r_base_mem[i_index] <= i_base_value;
        end
        if (i_cmd.rd_en) begin
            r_base_rdata <= r_base_mem[i_base_addr];
        end
    end

    assign o_vec_rdata  = r_vec_rdata;
    assign o_base_rdata = r_base_rdata;

endmodule

@@ hdl/csr_sparse_matrix_vector_product.sv @@
// channel   | dir | handshake    | payload
// ----------+-----+--------------+-------------------------------------------------------
// i_in      | in  | valid/ready  | mode, index, entry_value, base_value, entry_present,
//           |     |              | last_in_row
// o_out     | out | valid/ready  | row_index, row_sum, saturated
// i_cfg_*   | in  | write enable | add_to_base (one bit)
//
// one beat per cycle in while o_out does not hold the pipe; a row-end beat passes the
// store read, multiply, round, accumulate and base add registers in that order to o_out
// the accumulator is the only datapath loop: one 48-bit saturating add per unstalled cycle
// reset (synchronous, active low) clears the pipe, the row counter, the running sum and
// sets add_to_base; the stores keep whatever they hold
// a stalled o_out fills the stages behind it one by one; beats that give no result
// leave the pipe at the accumulator and wait on o_out only behind a held row end
module csr_sparse_matrix_vector_product (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    csrmv_in_if.sink    i_in,
    csrmv_out_if.source o_out
);
    import csrmv_pkg::*;

    logic                      r_add_to_base;
    logic [INDEX_W-1:0]        r_row;
    logic [INDEX_W-1:0]        n_row;

    // accept-side decode
    logic                      acc_in;
    t_ctl                      n1_ctl;
    logic                      n1_v;
    t_store_cmd                store_cmd;

    // stage 1: store read data plus the beat's value
    logic                      r1_v;
    t_ctl                      r1_ctl;
    logic signed [VALUE_W-1:0] r1_ev;
    logic signed [VALUE_W-1:0] vec_rdata;
    logic signed [SUM_W-1:0]   base_rdata;

    // stage 2: full product
    logic                      r2_v;
    t_ctl                      r2_ctl;
    logic signed [PROD_W-1:0]  n2_prod;
    logic signed [PROD_W-1:0]  r2_prod;
    logic signed [SUM_W-1:0]   r2_base;

    // stage 3: rounded product
    logic                      r3_v;
    t_ctl                      r3_ctl;
    logic signed [SUM_W-1:0]   r3_prod;
    logic signed [SUM_W-1:0]   r3_base;

    // accumulator
    logic signed [SUM_W-1:0]   r_acc;
    logic                      r_ovf;
    t_sat                      n_mac;
    logic signed [SUM_W-1:0]   n_sum;
    logic                      n_ovf;

    // stage 4: finished row total
    logic                      r4_v;
    logic [INDEX_W-1:0]        r4_row;
    logic signed [SUM_W-1:0]   r4_sum;
    logic                      r4_ovf;
    logic signed [SUM_W-1:0]   r4_base;

    // output register
    logic                      r_ov;
    logic [INDEX_W-1:0]        r_o_row;
    logic signed [SUM_W-1:0]   r_o_sum;
    logic                      r_o_sat;
    t_sat                      n_fin;

    // stage readiness, back to front
    logic                      out_free;
    logic                      rdy4;
    logic                      rdy3;
    logic                      adv3;
    logic                      rdy2;
    logic                      rdy1;

    always_comb begin
        out_free = !r_ov || o_out.ready;
        rdy4     = !r4_v || out_free;
        // beats that close no row leave at the accumulator, so only row ends wait on stage 4
        adv3     = r3_v && (!r3_ctl.is_last || rdy4);
        rdy3     = !r3_v || !r3_ctl.is_last || rdy4;
        rdy2     = !r2_v || rdy3;
        rdy1     = !r1_v || rdy2;
    end

    assign i_in.ready = rdy1;
    assign acc_in     = i_in.valid && rdy1;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_to_base <= 1'b1;
        end else if (i_cfg_we) begin
            r_add_to_base <= i_cfg_wdata;
        end
    end

    // decode of the incoming beat; the row number is settled here, in beat order
    always_comb begin
        n1_ctl.is_mac  = (i_in.mode == MODE_ROW) && i_in.entry_present;
        n1_ctl.is_last = (i_in.mode == MODE_ROW) && i_in.last_in_row;
        n1_ctl.is_rst  = (i_in.mode == MODE_RESTART);
        n1_ctl.row     = r_row;
        n1_v           = acc_in && (n1_ctl.is_mac || n1_ctl.is_last || n1_ctl.is_rst);

        store_cmd.wr_vec  = acc_in && (i_in.mode == MODE_LOAD_VEC);
        store_cmd.wr_base = acc_in && (i_in.mode == MODE_LOAD_BASE);
        store_cmd.rd_en   = rdy1;

        n_row = r_row;
        if (acc_in && n1_ctl.is_rst) begin
            n_row = '0;
        end else if (acc_in && n1_ctl.is_last) begin
            n_row = (r_row == ROW_LAST) ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    csrmv_stores u_stores (
        .i_clk         (i_clk),
        .i_cmd         (store_cmd),
        .i_index       (i_in.index),
        .i_base_addr   (r_row),
        .i_entry_value (i_in.entry_value),
        .i_base_value  (i_in.base_value),
        .o_vec_rdata   (vec_rdata),
        .o_base_rdata  (base_rdata)
    );

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (rdy1) begin
            r1_v <= n1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_ctl <= n1_ctl;
            r1_ev  <= i_in.entry_value;
        end
    end

    // stage 2: the one multiplier, 32 by 32 signed
    assign n2_prod = PROD_W'(r1_ev) * PROD_W'(vec_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (rdy2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_ctl  <= r1_ctl;
            r2_prod <= n2_prod;
            r2_base <= base_rdata;
        end
    end

    // stage 3: round to Q32.16
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (rdy3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_ctl  <= r2_ctl;
            r3_prod <= round_prod(r2_prod);
            r3_base <= r2_base;
        end
    end

    // running sum with saturation; the product is added only when the beat carries one
    always_comb begin
        n_mac = sat_add(r_acc, r3_prod);
        n_sum = r3_ctl.is_mac ? n_mac.value : r_acc;
        n_ovf = r_ovf || (r3_ctl.is_mac && n_mac.hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (adv3) begin
            if (r3_ctl.is_rst || r3_ctl.is_last) begin
                r_acc <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_acc <= n_sum;
                r_ovf <= n_ovf;
            end
        end
    end

    // stage 4: row total waiting for the base add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (rdy4) begin
            r4_v <= r3_v && r3_ctl.is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_row  <= r3_ctl.row;
            r4_sum  <= n_sum;
            r4_ovf  <= n_ovf;
            r4_base <= r3_base;
        end
    end

    // output register, base added here when enabled
    assign n_fin = sat_add(r4_sum, r4_base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_o_row <= r4_row;
            r_o_sum <= r_add_to_base ? n_fin.value : r4_sum;
            r_o_sat <= r4_ovf || (r_add_to_base && n_fin.hit);
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.row_index = r_o_row;
    assign o_out.row_sum   = r_o_sum;
    assign o_out.saturated = r_o_sat;

endmodule

@@ hdl/csrmv_checker.sv @@
module csrmv_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  csrmv_pkg::t_mode                   i_in_mode,
    input  logic                               i_in_last,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [csrmv_pkg::INDEX_W-1:0]      i_out_row,
    input  logic signed [csrmv_pkg::SUM_W-1:0] i_out_sum,
    input  logic                               i_out_sat
);
    import csrmv_pkg::*;

    logic row_end_beat;

    assign row_end_beat = i_in_valid && i_in_ready && (i_in_mode == MODE_ROW) && i_in_last;

    // reset empties the output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // an empty output means nothing in the pipe can block the input
    a_ready_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with no result pending");

    // with the sink held ready a row end comes out on o_out once it has passed every stage
    a_row_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (row_end_beat && i_out_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
            ##1 i_out_ready |=> i_out_valid)
        else $error("row result late");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_row) && $stable(i_out_sum) && $stable(i_out_sat)))
        else $error("result changed while stalled");

endmodule

bind csr_sparse_matrix_vector_product csrmv_checker u_csrmv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_mode   (i_in.mode),
    .i_in_last   (i_in.last_in_row),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_row   (o_out.row_index),
    .i_out_sum   (o_out.row_sum),
    .i_out_sat   (o_out.saturated)
);
